/* rtl/tabulated_inverse_cdf_sampler_core_defines.svh */
// Assertion macros for the tabulated inverse-CDF sampler.
// Used by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef TABULATED_INVERSE_CDF_SAMPLER_CORE_DEFINES_SVH
`define TABULATED_INVERSE_CDF_SAMPLER_CORE_DEFINES_SVH

// same-cycle implication
`define TICS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TICS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tics_pkg.sv */
// Shared types and constants for the tabulated inverse-CDF sampler.
// No dependencies; used by all RTL modules of the block but tics_ram.
package tics_pkg;

  localparam int unsigned CDF_W    = 25;
  localparam int unsigned VAL_W    = 24;
  localparam int unsigned SEL_W    = 2;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned NUM_REGS = 4;
  localparam int unsigned CFG_AW   = 4;
  localparam int unsigned CFG_DW   = 32;
  localparam logic [CNT_W-1:0] ENTRIES_RST = 9'd256;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } tics_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_EDGE,
    ST_EDGE_CHK,
    ST_SRCH_RD,
    ST_SRCH_UPD,
    ST_INTERP,
    ST_DIV,
    ST_MUL,
    ST_FINISH
  } tics_state_t;

  typedef enum logic [1:0] {
    RD_LO,
    RD_HI,
    RD_MID
  } tics_rd_sel_t;

  typedef enum logic [1:0] {
    RES_LO,
    RES_HI,
    RES_INTERP
  } tics_res_sel_t;

  typedef struct packed {
    logic          ld_write;
    logic          smp_start;
    tics_rd_sel_t  rd_sel;
    logic          cap_lo;
    logic          cap_hi;
    logic          srch_rd;
    logic          srch_upd;
    logic          div_init;
    logic          div_step;
    logic          mul;
    logic          res_load;
    tics_res_sel_t res_sel;
  } tics_ctl_t;

  typedef struct packed {
    logic tbl_ok;
    logic is_sample;
    logic below;
    logic above;
    logic span_gt1;
    logic flat;
    logic div_done;
  } tics_sts_t;

endpackage

/* rtl/tics_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tics_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/tics_ctrl.sv */
// Sequencer for the sampler: load writes, edge reads, binary search, divide, multiply.
// Depends on tics_pkg; drives tics_dp through tics_ctl_t.
module tics_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  tics_pkg::tics_sts_t sts_i,
  output tics_pkg::tics_ctl_t ctl_o,
  output logic                busy_o
);
  import tics_pkg::*;

  tics_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && sts_i.tbl_ok && sts_i.is_sample) begin
          state_nxt = ST_RD_FIRST;
        end
      end
      ST_RD_FIRST: state_nxt = ST_RD_LAST;
      ST_RD_LAST:  state_nxt = ST_EDGE;
      ST_EDGE:     state_nxt = ST_EDGE_CHK;
      ST_EDGE_CHK: begin
        if (sts_i.below || sts_i.above) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        if (sts_i.span_gt1) begin
          state_nxt = ST_SRCH_UPD;
        end else begin
          state_nxt = ST_INTERP;
        end
      end
      ST_SRCH_UPD: state_nxt = ST_SRCH_RD;
      ST_INTERP: begin
        if (sts_i.flat) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:    state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o         = '0;
    ctl_o.rd_sel  = RD_LO;
    ctl_o.res_sel = RES_LO;
    unique case (state_r)
      ST_IDLE: begin
        if (start && sts_i.tbl_ok) begin
          ctl_o.smp_start = sts_i.is_sample;
          ctl_o.ld_write  = !sts_i.is_sample;
        end
      end
      ST_RD_FIRST: ctl_o.rd_sel = RD_LO;
      ST_RD_LAST: begin
        ctl_o.rd_sel = RD_HI;
        ctl_o.cap_lo = 1'b1;
      end
      ST_EDGE: ctl_o.cap_hi = 1'b1;
      ST_EDGE_CHK: begin
        priority if (sts_i.below) begin
          ctl_o.res_load = 1'b1;
          ctl_o.res_sel  = RES_LO;
        end else if (sts_i.above) begin
          ctl_o.res_load = 1'b1;
          ctl_o.res_sel  = RES_HI;
        end else begin
          ctl_o.res_load = 1'b0;
        end
      end
      ST_SRCH_RD: begin
        if (sts_i.span_gt1) begin
          ctl_o.rd_sel  = RD_MID;
          ctl_o.srch_rd = 1'b1;
        end
      end
      ST_SRCH_UPD: ctl_o.srch_upd = 1'b1;
      ST_INTERP: begin
        if (sts_i.flat) begin
          ctl_o.res_load = 1'b1;
          ctl_o.res_sel  = RES_LO;
        end else begin
          ctl_o.div_init = 1'b1;
        end
      end
      ST_DIV: ctl_o.div_step = 1'b1;
      ST_MUL: ctl_o.mul = 1'b1;
      ST_FINISH: begin
        ctl_o.res_load = 1'b1;
        ctl_o.res_sel  = RES_INTERP;
      end
      default: ctl_o.rd_sel = RD_LO;
    endcase
  end

  assign busy_o = (state_r != ST_IDLE);

endmodule

/* rtl/tics_dp.sv */
// Datapath: table RAMs, search bounds, restoring divider, scaler, result register.
// Depends on tics_pkg and tics_ram; commanded by tics_ctrl.
module tics_dp #(
  parameter int unsigned TABLE_DEPTH   = 256,
  parameter int unsigned TABLE_COUNT   = 4,
  parameter int unsigned FRACTION_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tics_pkg::tics_ctl_t                  ctl_i,
  output tics_pkg::tics_sts_t                  sts_o,
  input  logic                                 in_cmd,
  input  logic [tics_pkg::SEL_W-1:0]           in_table_sel,
  input  logic [tics_pkg::IDX_W-1:0]           in_entry_index,
  input  logic [tics_pkg::CDF_W-1:0]           in_cdf_entry,
  input  logic [tics_pkg::VAL_W-1:0]           in_value_entry,
  input  logic [tics_pkg::VAL_W-1:0]           in_probability,
  input  logic [tics_pkg::CNT_W-1:0]           entries_i [tics_pkg::NUM_REGS],
  output logic [tics_pkg::VAL_W-1:0]           out_sampled_value,
  output logic [tics_pkg::SEL_W-1:0]           out_from_table,
  output logic                                 out_strobe
);
  import tics_pkg::*;

  localparam int unsigned DEPTH_ALL = TABLE_COUNT * TABLE_DEPTH;
  localparam int unsigned AW        = $clog2(DEPTH_ALL);
  localparam int unsigned IW        = $clog2(TABLE_DEPTH);
  localparam int unsigned NW        = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW        = (NW > CNT_W) ? NW : CNT_W;
  localparam int unsigned FB        = FRACTION_BITS;
  localparam int unsigned DCW       = $clog2(FB);
  localparam int unsigned PW        = FB + VAL_W;

  // table RAMs
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic [CDF_W-1:0] rd_cdf;
  logic [VAL_W-1:0] rd_val;

  // request and search state
  logic [SEL_W-1:0] t_r;
  logic [VAL_W-1:0] p_r;
  logic [AW-1:0]    base_r;
  logic [IW-1:0]    lo_r, hi_r, mid_r;
  logic [CDF_W-1:0] clo_r, chi_r;
  logic [VAL_W-1:0] vlo_r, vhi_r;

  // divider and scaler
  logic [CDF_W-1:0] rem_r, den_r;
  logic [FB-1:0]    quo_r;
  logic [DCW-1:0]   cnt_r;
  logic [VAL_W-1:0] d_r;
  logic             up_r;
  logic [PW-1:0]    prod_r;

  // result
  logic [VAL_W-1:0] res_r;
  logic [SEL_W-1:0] from_r;
  logic             strobe_r;

  logic [CW-1:0]    n_raw, n_use;
  logic [IW-1:0]    hi_init;
  logic [IW-1:0]    mid_c;
  logic [IW-1:0]    rd_idx;
  logic [IW-1:0]    span;
  logic [CDF_W-1:0] p_ext;
  logic [CDF_W:0]   rem2, rem_diff;
  logic             ge;
  logic [VAL_W-1:0] step;
  logic [VAL_W-1:0] res_interp;
  logic [VAL_W-1:0] res_sel_val;
  logic             idx_ok;

  assign idx_ok  = 32'(in_entry_index) < TABLE_DEPTH;
  assign wr_en   = ctl_i.ld_write && idx_ok;
  assign wr_addr = AW'(32'(in_table_sel) * TABLE_DEPTH + 32'(in_entry_index));

  assign n_raw   = CW'(entries_i[in_table_sel]);
  assign n_use   = (n_raw < CW'(2)) ? CW'(2) :
                   ((n_raw > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : n_raw);
  assign hi_init = IW'(n_use - CW'(1));

  assign mid_c = IW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign span  = hi_r - lo_r;

  always_comb begin
    unique case (ctl_i.rd_sel)
      RD_LO:   rd_idx = lo_r;
      RD_HI:   rd_idx = hi_r;
      RD_MID:  rd_idx = mid_c;
      default: rd_idx = lo_r;
    endcase
  end

  assign rd_addr = base_r + AW'(rd_idx);

  tics_ram #(.WIDTH(CDF_W), .DEPTH(DEPTH_ALL)) u_cdf_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_cdf_entry),
    .raddr (rd_addr),
    .rdata (rd_cdf)
  );

  tics_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH_ALL)) u_val_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_value_entry),
    .raddr (rd_addr),
    .rdata (rd_val)
  );

  assign p_ext    = {1'b0, p_r};
  assign rem2     = {rem_r, 1'b0};
  assign rem_diff = rem2 - {1'b0, den_r};
  assign ge       = rem2 >= {1'b0, den_r};

  assign step       = prod_r[PW-1:FB];
  assign res_interp = up_r ? (vlo_r + step) : (vlo_r - step);

  always_comb begin
    unique case (ctl_i.res_sel)
      RES_LO:     res_sel_val = vlo_r;
      RES_HI:     res_sel_val = vhi_r;
      RES_INTERP: res_sel_val = res_interp;
      default:    res_sel_val = vlo_r;
    endcase
  end

  assign sts_o.tbl_ok    = 32'(in_table_sel) < TABLE_COUNT;
  assign sts_o.is_sample = (in_cmd == CMD_SAMPLE);
  assign sts_o.below     = p_ext <= clo_r;
  assign sts_o.above     = p_ext >= chi_r;
  assign sts_o.span_gt1  = span > IW'(1);
  assign sts_o.flat      = (chi_r <= clo_r) || (p_ext < clo_r);
  assign sts_o.div_done  = (cnt_r == DCW'(FB - 1));

  always_ff @(posedge clk) begin
    if (ctl_i.smp_start) begin
      t_r    <= in_table_sel;
      p_r    <= in_probability;
      base_r <= AW'(32'(in_table_sel) * TABLE_DEPTH);
      lo_r   <= '0;
      hi_r   <= hi_init;
    end
    if (ctl_i.cap_lo) begin
      clo_r <= rd_cdf;
      vlo_r <= rd_val;
    end
    if (ctl_i.cap_hi) begin
      chi_r <= rd_cdf;
      vhi_r <= rd_val;
    end
    if (ctl_i.srch_rd) begin
      mid_r <= mid_c;
    end
    // keep cdf[lo] <= p < cdf[hi]
    if (ctl_i.srch_upd) begin
      if (rd_cdf <= p_ext) begin
        lo_r  <= mid_r;
        clo_r <= rd_cdf;
        vlo_r <= rd_val;
      end else begin
        hi_r  <= mid_r;
        chi_r <= rd_cdf;
        vhi_r <= rd_val;
      end
    end
    if (ctl_i.div_init) begin
      rem_r <= p_ext - clo_r;
      den_r <= chi_r - clo_r;
      quo_r <= '0;
      cnt_r <= '0;
      up_r  <= vhi_r >= vlo_r;
      d_r   <= (vhi_r >= vlo_r) ? (vhi_r - vlo_r) : (vlo_r - vhi_r);
    end
    // one quotient bit per cycle; remainder stays below den
    if (ctl_i.div_step) begin
      rem_r <= ge ? rem_diff[CDF_W-1:0] : rem2[CDF_W-1:0];
      quo_r <= {quo_r[FB-2:0], ge};
      cnt_r <= cnt_r + DCW'(1);
    end
    if (ctl_i.mul) begin
      prod_r <= PW'(quo_r) * PW'(d_r);
    end
    if (ctl_i.res_load) begin
      res_r  <= res_sel_val;
      from_r <= t_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl_i.res_load;
    end
  end

  assign out_sampled_value = res_r;
  assign out_from_table    = from_r;
  assign out_strobe        = strobe_r;

endmodule

/* rtl/tabulated_inverse_cdf_sampler_core.sv */
// Top level of the tabulated inverse-CDF sampler: APB register file plus core.
// Depends on tics_pkg, tics_ctrl, tics_dp (with tics_ram) and the defines header.
//
// Usage:
//   Requests enter on start/busy: a request is taken at a clock edge with start
//   high and busy low. in_cmd selects a load (writes entry in_entry_index of
//   table in_table_sel) or a sample (draws from table in_table_sel with
//   in_probability). A load completes at the accepting edge and never raises
//   busy. A sample raises busy until its result is produced.
//   Each sample result appears on out_sampled_value/out_from_table for one cycle
//   with out_strobe high. The receiver cannot stall; it must take the result in
//   that cycle. A sample on a table beyond the table count gives no result.
//   A sample reads both table ends; a probability on or beyond a table end gives
//   that end's value. Else a binary search of h <= ceil(log2(n-1)) halvings (one
//   RAM read per halving) finds the interval; a zero-width interval gives its
//   lower value, else the divider makes FRACTION_BITS quotient bits, one per
//   cycle, before scaling. busy drops in the result cycle; one sample in flight.
//   Entry counts sit at byte addresses 0, 4, 8, 12 of the APB port; write them
//   only while busy is low. Reset sets every count to 256 and leaves the table
//   RAMs undefined; sample only entries that were loaded.
module tabulated_inverse_cdf_sampler_core #(
  parameter int unsigned TABLE_DEPTH   = 256,
  parameter int unsigned TABLE_COUNT   = 4,
  parameter int unsigned FRACTION_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_cmd,
  input  logic [tics_pkg::SEL_W-1:0]     in_table_sel,
  input  logic [tics_pkg::IDX_W-1:0]     in_entry_index,
  input  logic [tics_pkg::CDF_W-1:0]     in_cdf_entry,
  input  logic [tics_pkg::VAL_W-1:0]     in_value_entry,
  input  logic [tics_pkg::VAL_W-1:0]     in_probability,
  output logic                           out_strobe,
  output logic [tics_pkg::VAL_W-1:0]     out_sampled_value,
  output logic [tics_pkg::SEL_W-1:0]     out_from_table,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tics_pkg::CFG_AW-1:0]    paddr,
  input  logic [tics_pkg::CFG_DW-1:0]    pwdata,
  output logic [tics_pkg::CFG_DW-1:0]    prdata,
  output logic                           pready
);
  import tics_pkg::*;

  `include "tabulated_inverse_cdf_sampler_core_defines.svh"

  logic [CNT_W-1:0] entries_r [NUM_REGS];
  logic             cfg_wr;
  logic [1:0]       cfg_idx;
  tics_ctl_t        ctl;
  tics_sts_t        sts;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = CFG_DW'(entries_r[cfg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        entries_r[i] <= ENTRIES_RST;
      end
    end else if (cfg_wr) begin
      entries_r[cfg_idx] <= pwdata[CNT_W-1:0];
    end
  end

  tics_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy_o (busy)
  );

  tics_dp #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .TABLE_COUNT   (TABLE_COUNT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl_i             (ctl),
    .sts_o             (sts),
    .in_cmd            (in_cmd),
    .in_table_sel      (in_table_sel),
    .in_entry_index    (in_entry_index),
    .in_cdf_entry      (in_cdf_entry),
    .in_value_entry    (in_value_entry),
    .in_probability    (in_probability),
    .entries_i         (entries_r),
    .out_sampled_value (out_sampled_value),
    .out_from_table    (out_from_table),
    .out_strobe        (out_strobe)
  );

  `TICS_ASSERT_NXT(a_strobe_single, out_strobe, !out_strobe, "result strobe held two cycles")
  `TICS_ASSERT_NXT(a_load_no_busy, start && !busy && (in_cmd == CMD_LOAD), !busy, "load raised busy")
  `TICS_ASSERT_IMP(a_strobe_idle, out_strobe, !busy, "result shown while still busy")

endmodule

/* bench/tabulated_inverse_cdf_sampler_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for tabulated_inverse_cdf_sampler_core: loads and draws on all four tables.
// Needs tics_pkg and the sampler RTL; predicts every draw and scoreboards out_strobe results.

module tabulated_inverse_cdf_sampler_core_tb;
  import tics_pkg::*;

  localparam int unsigned DEPTH       = 256;
  localparam int unsigned TABLES      = 4;
  localparam int unsigned FRAC        = 24;
  localparam int unsigned SETTLE      = 60;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned STREAM_LEN  = 70;
  localparam logic [PHASES-1:0][CNT_W-1:0] EXTREME_COUNTS =
    {9'd3, 9'd2, 9'd1, 9'd511, 9'd0, 9'd256};

  typedef struct packed {
    tics_cmd_t        cmd;
    logic [SEL_W-1:0] sel;
    logic [IDX_W-1:0] idx;
    logic [CDF_W-1:0] cdf;
    logic [VAL_W-1:0] val;
    logic [VAL_W-1:0] prob;
    logic             known;
    logic [VAL_W-1:0] want;
  } sampler_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [SEL_W-1:0] tbl;
  } draw_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              start          = 1'b0;
  logic              in_cmd         = 1'b0;
  logic [SEL_W-1:0]  in_table_sel   = '0;
  logic [IDX_W-1:0]  in_entry_index = '0;
  logic [CDF_W-1:0]  in_cdf_entry   = '0;
  logic [VAL_W-1:0]  in_value_entry = '0;
  logic [VAL_W-1:0]  in_probability = '0;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [CFG_AW-1:0] paddr          = '0;
  logic [CFG_DW-1:0] pwdata         = '0;
  logic              busy;
  logic              out_strobe;
  logic [VAL_W-1:0]  out_sampled_value;
  logic [SEL_W-1:0]  out_from_table;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  tabulated_inverse_cdf_sampler_core #(
    .TABLE_DEPTH  (DEPTH),
    .TABLE_COUNT  (TABLES),
    .FRACTION_BITS(FRAC)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_table_sel     (in_table_sel),
    .in_entry_index   (in_entry_index),
    .in_cdf_entry     (in_cdf_entry),
    .in_value_entry   (in_value_entry),
    .in_probability   (in_probability),
    .out_strobe       (out_strobe),
    .out_sampled_value(out_sampled_value),
    .out_from_table   (out_from_table),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  logic [CDF_W-1:0] cdf_tab [TABLES][DEPTH];
  logic [VAL_W-1:0] val_tab [TABLES][DEPTH];
  logic [CNT_W-1:0] count_reg [TABLES];
  draw_t            pending_draws [$];
  sampler_req_t     directed_rows [$];
  int unsigned      errors      = 0;
  int unsigned      cycles      = 0;
  int unsigned      n_draws     = 0;
  int unsigned      n_loads     = 0;
  int unsigned      n_settings  = 0;
  int unsigned      burst_left  = 0;
  bit               steady      = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tabulated_inverse_cdf_sampler_core_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    draw_t w;
    if (rst_n && out_strobe) begin
      if (pending_draws.size() == 0) begin
        $error("unexpected result: sampled_value %h from_table %0d",
               out_sampled_value, out_from_table);
        errors++;
      end else begin
        w = pending_draws.pop_front();
        n_draws++;
        if (out_sampled_value !== w.value) begin
          $error("sampled_value expected %h actual %h", w.value, out_sampled_value);
          errors++;
        end
        if (out_from_table !== w.tbl) begin
          $error("from_table expected %0d actual %0d", w.tbl, out_from_table);
          errors++;
        end
      end
    end
  end

  function automatic int unsigned used_count(int unsigned t);
    int unsigned n;
    n = 32'(count_reg[t]);
    if (n < 2) n = 2;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  function automatic logic [VAL_W-1:0] interp_draw(int unsigned t, logic [VAL_W-1:0] p);
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      mid;
    logic [CDF_W-1:0] clo;
    logic [CDF_W-1:0] chi;
    logic [VAL_W-1:0] vlo;
    logic [VAL_W-1:0] vhi;
    logic [VAL_W-1:0] d;
    logic [63:0]      f;
    logic [63:0]      s;
    lo = 0;
    hi = used_count(t) - 1;
    if (p <= cdf_tab[t][0]) return val_tab[t][0];
    if (p >= cdf_tab[t][hi]) return val_tab[t][hi];
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (cdf_tab[t][mid] <= p) lo = mid;
      else hi = mid;
    end
    clo = cdf_tab[t][lo];
    chi = cdf_tab[t][hi];
    vlo = val_tab[t][lo];
    vhi = val_tab[t][hi];
    if (chi <= clo || p < clo) return vlo;
    f = ((64'(p) - 64'(clo)) << FRAC) / (64'(chi) - 64'(clo));
    if (f > (64'd1 << FRAC)) f = 64'd1 << FRAC;
    d = (vhi >= vlo) ? vhi - vlo : vlo - vhi;
    s = (f * 64'(d)) >> FRAC;
    return (vhi >= vlo) ? vlo + s[VAL_W-1:0] : vlo - s[VAL_W-1:0];
  endfunction

  function automatic void queue_row(sampler_req_t r);
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void note_request(sampler_req_t r);
    draw_t w;
    if (r.cmd == CMD_LOAD) begin
      cdf_tab[r.sel][r.idx] = r.cdf;
      val_tab[r.sel][r.idx] = r.val;
      n_loads++;
    end else begin
      w.value = r.known ? r.want : interp_draw(r.sel, r.prob);
      w.tbl   = r.sel;
      pending_draws = {pending_draws, w};
    end
  endfunction

  task automatic issue(sampler_req_t r);
    start          <= 1'b1;
    in_cmd         <= r.cmd;
    in_table_sel   <= r.sel;
    in_entry_index <= r.idx;
    in_cdf_entry   <= r.cdf;
    in_value_entry <= r.val;
    in_probability <= r.prob;
    do @(posedge clk); while (busy);
    note_request(r);
  endtask

  task automatic idle(int unsigned k);
    start <= 1'b0;
    repeat (k) @(posedge clk);
  endtask

  task automatic pace();
    if (!steady) begin
      if (burst_left == 0) begin
        idle($urandom_range(1, 12));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_draws.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_access(logic wr, int unsigned idx, logic [CFG_DW-1:0] data);
    logic [CFG_AW-1:0] a;
    logic [CFG_DW-1:0] want_rd;
    a = CFG_AW'(idx * 4);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      count_reg[idx] = data[CNT_W-1:0];
    end else begin
      want_rd = '0;
      want_rd[CNT_W-1:0] = count_reg[idx];
      if (prdata !== want_rd) begin
        $error("entries_table%0d expected %h actual %h", idx, want_rd, prdata);
        errors++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // rising cdf column with occasional ties; values random, rising or falling
  task automatic fill_table(int unsigned t);
    int unsigned  n;
    int unsigned  c;
    int unsigned  step;
    int unsigned  v;
    int unsigned  mode;
    sampler_req_t r;
    n    = used_count(t);
    c    = $urandom_range(0, 24'h200000);
    step = (25'h1000000 - c) / n;
    mode = $urandom_range(0, 2);
    v    = (mode == 2) ? 24'hFFFFFF - $urandom_range(0, 24'hFFFF) : $urandom_range(0, 24'hFFFF);
    for (int unsigned i = 0; i < n; i++) begin
      r      = '0;
      r.cmd  = CMD_LOAD;
      r.sel  = SEL_W'(t);
      r.idx  = IDX_W'(i);
      r.cdf  = CDF_W'(c);
      r.val  = VAL_W'((mode == 0) ? $urandom : v);
      r.prob = VAL_W'($urandom);
      if (i == n - 1 && $urandom_range(0, 1) == 1) r.cdf = 25'h1000000;
      pace();
      issue(r);
      c += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, step);
      if (mode == 1) v += $urandom_range(0, 24'hF00000 / n);
      if (mode == 2) v -= $urandom_range(0, 24'hF00000 / n);
    end
  endtask

  task automatic random_request();
    sampler_req_t r;
    int unsigned  t;
    int unsigned  k;
    int unsigned  pick;
    r      = '0;
    t      = $urandom_range(0, TABLES - 1);
    r.sel  = SEL_W'(t);
    r.idx  = IDX_W'($urandom);
    r.cdf  = CDF_W'($urandom);
    r.val  = VAL_W'($urandom);
    r.prob = VAL_W'($urandom);
    pick   = $urandom_range(0, 99);
    if (pick < 12) begin
      r.cmd = CMD_LOAD;
    end else begin
      r.cmd = CMD_SAMPLE;
      k = $urandom_range(0, used_count(t) - 1);
      if (pick < 20) r.prob = '0;
      else if (pick < 26) r.prob = '1;
      else if (pick < 46) r.prob = cdf_tab[t][k][VAL_W-1:0];
      else if (pick < 53) r.prob = cdf_tab[t][k][VAL_W-1:0] - 1'b1;
      else if (pick < 60) r.prob = cdf_tab[t][k][VAL_W-1:0] + 1'b1;
    end
    pace();
    issue(r);
  endtask

  initial begin : stimulus
    int unsigned      raw;
    logic [CFG_DW-1:0] wdata;
    for (int t = 0; t < TABLES; t++) count_reg[t] = ENTRIES_RST;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int t = 0; t < TABLES; t++) reg_access(1'b0, t, '0);
    reg_access(1'b1, 0, 32'd4);
    reg_access(1'b1, 1, 32'd0);
    reg_access(1'b1, 2, 32'd3);
    reg_access(1'b1, 3, 32'd1);
    n_settings++;

    // table 0: four entries with a tie in the middle
    queue_row('{CMD_LOAD, 2'd0, 8'd0, 25'h0100000, 24'd1000, 24'd0, 1'b0, 24'd0});
    queue_row('{CMD_LOAD, 2'd0, 8'd1, 25'h0400000, 24'd5000, 24'd0, 1'b0, 24'd0});
    queue_row('{CMD_LOAD, 2'd0, 8'd2, 25'h0400000, 24'd9000, 24'd0, 1'b0, 24'd0});
    queue_row('{CMD_LOAD, 2'd0, 8'd3, 25'h1000000, 24'hFFFFFF, 24'd0, 1'b0, 24'd0});
    queue_row('{CMD_SAMPLE, 2'd0, 8'd0, 25'd0, 24'd0, 24'h000000, 1'b1, 24'd1000});
    queue_row('{CMD_SAMPLE, 2'd0, 8'd0, 25'd0, 24'd0, 24'h100000, 1'b1, 24'd1000});
    queue_row('{CMD_SAMPLE, 2'd0, 8'd0, 25'd0, 24'd0, 24'h400000, 1'b0, 24'd0});
    queue_row('{CMD_SAMPLE, 2'd0, 8'd0, 25'd0, 24'd0, 24'h250000, 1'b0, 24'd0});
    queue_row('{CMD_SAMPLE, 2'd0, 8'd0, 25'd0, 24'd0, 24'hFFFFFF, 1'b0, 24'd0});
    // table 1: count 0 acts as 2, falling cdf
    queue_row('{CMD_LOAD, 2'd1, 8'd0, 25'h0800000, 24'd7, 24'd0, 1'b0, 24'd0});
    queue_row('{CMD_LOAD, 2'd1, 8'd1, 25'h0200000, 24'd99, 24'd0, 1'b0, 24'd0});
    queue_row('{CMD_SAMPLE, 2'd1, 8'd0, 25'd0, 24'd0, 24'h500000, 1'b1, 24'd7});
    queue_row('{CMD_SAMPLE, 2'd1, 8'd0, 25'd0, 24'd0, 24'h900000, 1'b1, 24'd99});
    // table 2: falling values over the full cdf range
    queue_row('{CMD_LOAD, 2'd2, 8'd0, 25'h0000000, 24'hFFFFFF, 24'd0, 1'b0, 24'd0});
    queue_row('{CMD_LOAD, 2'd2, 8'd1, 25'h0800000, 24'h800000, 24'd0, 1'b0, 24'd0});
    queue_row('{CMD_LOAD, 2'd2, 8'd2, 25'h1FFFFFF, 24'h000000, 24'd0, 1'b0, 24'd0});
    queue_row('{CMD_SAMPLE, 2'd2, 8'd0, 25'd0, 24'd0, 24'h400000, 1'b0, 24'd0});
    queue_row('{CMD_SAMPLE, 2'd2, 8'd0, 25'd0, 24'd0, 24'hC00000, 1'b0, 24'd0});
    queue_row('{CMD_SAMPLE, 2'd2, 8'd0, 25'd0, 24'd0, 24'h000000, 1'b1, 24'hFFFFFF});
    // table 3: count 1 acts as 2, narrow interval
    queue_row('{CMD_LOAD, 2'd3, 8'd0, 25'h0000001, 24'h000000, 24'd0, 1'b0, 24'd0});
    queue_row('{CMD_LOAD, 2'd3, 8'd1, 25'h0000003, 24'hFFFFFF, 24'd0, 1'b0, 24'd0});
    queue_row('{CMD_SAMPLE, 2'd3, 8'd0, 25'd0, 24'd0, 24'h000002, 1'b0, 24'd0});
    queue_row('{CMD_SAMPLE, 2'd3, 8'd0, 25'd0, 24'd0, 24'hFFFFFF, 1'b1, 24'hFFFFFF});

    foreach (directed_rows[i]) issue(directed_rows[i]);
    drain();

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      steady     = (ph == 2);
      burst_left = 0;
      for (int unsigned t = 0; t < TABLES; t++) begin
        if (t == ph % TABLES) raw = 32'(EXTREME_COUNTS[ph]);
        else if ($urandom_range(0, 7) == 0) raw = $urandom_range(25, 100);
        else raw = $urandom_range(2, 24);
        wdata = ($urandom_range(0, 1) == 1) ? $urandom : '0;
        wdata[CNT_W-1:0] = CNT_W'(raw);
        reg_access(1'b1, t, wdata);
      end
      n_settings++;
      for (int unsigned t = 0; t < TABLES; t++) reg_access(1'b0, t, '0);
      for (int unsigned t = 0; t < TABLES; t++) fill_table(t);
      repeat (STREAM_LEN) random_request();
      drain();
    end

    $display("tabulated_inverse_cdf_sampler_core_tb: covered %0d draws, %0d entry loads,",
             n_draws, n_loads);
    $display("tabulated_inverse_cdf_sampler_core_tb: over %0d sets of table entry counts",
             n_settings);
    if (errors == 0) begin
      $display("tabulated_inverse_cdf_sampler_core_tb: done, clean");
    end else begin
      $display("tabulated_inverse_cdf_sampler_core_tb: done, errors");
    end
    $finish;
  end

endmodule

/* tabulated_inverse_cdf_sampler_core.f */
+incdir+rtl
rtl/tics_pkg.sv
rtl/tics_ram.sv
rtl/tics_ctrl.sv
rtl/tics_dp.sv
rtl/tabulated_inverse_cdf_sampler_core.sv
bench/tabulated_inverse_cdf_sampler_core_tb.sv
